// File: hdl/synth_voice_modulation_calc_core_defines.svh
// Assertion macros for the voice modulation calculator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SYNTH_VOICE_MODULATION_CALC_CORE_DEFINES_SVH
`define SYNTH_VOICE_MODULATION_CALC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SVMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SVMC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/svmc_pkg.sv
// Shared types and constants for the voice modulation calculator.
// No dependencies; used by the channel interfaces, the multiplier and the top level.
package svmc_pkg;

    // Audio sample rate the Q0.24 frequency constants are derived for
    localparam int unsigned SAMPLE_RATE_HZ = 44100;

    // Payload types
    typedef logic [1:0]         t_req_type;
    typedef logic signed [24:0] t_src_val;
    typedef logic [23:0]        t_freq;
    typedef logic [15:0]        t_knob;
    typedef logic [2:0]         t_cfg_idx;

    // Source codes
    localparam t_req_type REQ_KEY  = 2'd0;
    localparam t_req_type REQ_LFO  = 2'd1;
    localparam t_req_type REQ_ENV  = 2'd2;
    localparam t_req_type REQ_BEND = 2'd3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_CUTOFF_BASE   = 3'd0;
    localparam t_cfg_idx CFG_KEY_TRACK     = 3'd1;
    localparam t_cfg_idx CFG_FILT_LFO_KNOB = 3'd2;
    localparam t_cfg_idx CFG_FILT_ENV_KNOB = 3'd3;
    localparam t_cfg_idx CFG_ENV_INVERT    = 3'd4;
    localparam t_cfg_idx CFG_BEND_FILT     = 3'd5;
    localparam t_cfg_idx CFG_BEND_OSC      = 3'd6;
    localparam t_cfg_idx CFG_VIB_DEPTH     = 3'd7;

    // Frequency constants, Q0.24 cycles per sample, rounded
    localparam longint unsigned ONE_Q24 = 64'd16777216;
    localparam longint unsigned CPS33_FULL =
        (64'd33 * ONE_Q24 + 64'(SAMPLE_RATE_HZ) / 64'd2) / 64'(SAMPLE_RATE_HZ);
    localparam longint unsigned CPS20_FULL =
        (64'd20 * ONE_Q24 + 64'(SAMPLE_RATE_HZ) / 64'd2) / 64'(SAMPLE_RATE_HZ);
    localparam t_freq CPS33      = t_freq'(CPS33_FULL);
    localparam t_freq CPS20      = t_freq'(CPS20_FULL);
    localparam t_freq CUTOFF_MAX = 24'd16760438;   // floor(0.999 * 2^24)
    localparam t_freq FREQ_MAX   = 24'hFFFFFF;

    // 1 / 0.093424 in Q.16 for keyboard tracking
    localparam logic [19:0] TRACK_RECIP = 20'd701490;

    // 2^f polynomial coefficients, Q.16
    localparam logic [15:0] EXP_C1 = 16'd45584;
    localparam logic [15:0] EXP_C2 = 16'd14823;
    localparam logic [15:0] EXP_C3 = 16'd5121;

    // Divide by six: x * ceil(2^34 / 6) >> 34 is exact for 32-bit x
    localparam logic [31:0] RECIP6       = 32'hAAAAAAAB;
    localparam int          RECIP6_SHIFT = 34;
    localparam int          QUOT_W       = 29;

    // Shared multiplier and accumulator widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 34;

    // Octave shift range of the exp2 scaler
    localparam int                       EXPN_W   = 7;
    localparam logic signed [EXPN_W-1:0] EXPN_MIN = -7'sd40;
    localparam logic signed [EXPN_W-1:0] EXPN_MAX = 7'sd8;

endpackage

// File: hdl/svmc_req_if.sv
// Request channel: one modulation source update per transaction.
// Depends on svmc_pkg for payload types.
interface svmc_req_if;
    logic               valid;
    logic               ready;
    svmc_pkg::t_req_type req_type;
    svmc_pkg::t_src_val  source_value;

    modport source (output valid, req_type, source_value, input ready);
    modport sink   (input valid, req_type, source_value, output ready);
endinterface

// File: hdl/svmc_rsp_if.sv
// Response channel: cutoff and oscillator frequencies per transaction.
// Depends on svmc_pkg for payload types.
interface svmc_rsp_if;
    logic            valid;
    logic            ready;
    svmc_pkg::t_freq filter_cutoff;
    svmc_pkg::t_freq osc_freq;
    svmc_pkg::t_freq sub_osc_freq;
    logic            osc_sync;

    modport source (output valid, filter_cutoff, osc_freq, sub_osc_freq, osc_sync,
                    input ready);
    modport sink   (input valid, filter_cutoff, osc_freq, sub_osc_freq, osc_sync,
                    output ready);
endinterface

// File: hdl/svmc_mul.sv
// Shared signed multiplier with registered product and load enable.
// Depends on svmc_pkg for operand widths.
module svmc_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [svmc_pkg::MUL_W-1:0]   i_a,
    input  logic signed [svmc_pkg::MUL_W-1:0]   i_b,
    output logic signed [svmc_pkg::PROD_W-1:0]  o_p
);

    logic signed [svmc_pkg::PROD_W-1:0] r_p;

    // product holds when no operation is issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: hdl/synth_voice_modulation_calc_core.sv
// Voice modulation calculator: filter cutoff and oscillator frequencies from stored sources.
// Depends on svmc_pkg, svmc_req_if, svmc_rsp_if, svmc_mul and the defines header.
// A new request is taken only in the idle state, after the previous one has left the sequencer.
// Each request issues one 33x33 multiplier 22 times in sequence.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active low) clears config, stored sources and the sequencer.
`include "synth_voice_modulation_calc_core_defines.svh"

module synth_voice_modulation_calc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  svmc_pkg::t_cfg_idx   i_cfg_idx,
    input  svmc_pkg::t_knob      i_cfg_data,
    svmc_req_if.sink             i_req,
    svmc_rsp_if.source           o_rsp
);

    localparam int MUL_W  = svmc_pkg::MUL_W;
    localparam int PROD_W = svmc_pkg::PROD_W;
    localparam int ACC_W  = svmc_pkg::ACC_W;
    localparam int EXPN_W = svmc_pkg::EXPN_W;

    typedef logic [4:0] t_state;

    localparam t_state ST_IDLE  = 5'd0;
    localparam t_state ST_LK2   = 5'd1;
    localparam t_state ST_LK4   = 5'd2;
    localparam t_state ST_LTERM = 5'd3;
    localparam t_state ST_EK2   = 5'd4;
    localparam t_state ST_EK4   = 5'd5;
    localparam t_state ST_ETERM = 5'd6;
    localparam t_state ST_KT    = 5'd7;
    localparam t_state ST_KTD   = 5'd8;
    localparam t_state ST_FBEND = 5'd9;
    localparam t_state ST_FEXP  = 5'd10;
    localparam t_state ST_FP2   = 5'd11;
    localparam t_state ST_FP1   = 5'd12;
    localparam t_state ST_FSCL  = 5'd13;
    localparam t_state ST_FSQ   = 5'd14;
    localparam t_state ST_FSQ2  = 5'd15;
    localparam t_state ST_VIB   = 5'd16;
    localparam t_state ST_DIV6  = 5'd17;
    localparam t_state ST_OBEND = 5'd18;
    localparam t_state ST_OEXP  = 5'd19;
    localparam t_state ST_OP2   = 5'd20;
    localparam t_state ST_OP1   = 5'd21;
    localparam t_state ST_OSCL  = 5'd22;
    localparam t_state ST_DONE  = 5'd23;

    // zero-extend an unsigned value into a signed multiplier operand
    function automatic logic signed [MUL_W-1:0] f_uop(input logic [MUL_W-2:0] x);
        return $signed({1'b0, x});
    endfunction

    // mag * 2^n / 2^16 with n in [-40, 8]: one right shift of mag * 2^8
    function automatic logic [39:0] f_exp_shift(input logic [47:0] y,
                                                input logic signed [EXPN_W-1:0] n);
        logic [55:0] z;
        logic [6:0]  sh;
        z  = {y, 8'b0};
        sh = 7'd24 - $unsigned(n);
        return 40'(z >> sh);
    endfunction

    // configuration registers
    svmc_pkg::t_knob r_cutoff_base, r_key_track, r_lfo_knob, r_env_knob;
    svmc_pkg::t_knob r_bend_fdepth, r_bend_odepth, r_vib_depth;
    logic            r_env_inv;

    // stored modulation sources
    svmc_pkg::t_freq    r_key_pitch;
    logic signed [15:0] r_lfo;
    logic signed [16:0] r_env;
    logic signed [15:0] r_bend;

    // sequencer and datapath registers
    t_state                    r_state, n_state;
    logic signed [ACC_W-1:0]   r_acc;
    logic [31:0]               r_mag;
    logic [15:0]               r_frac;
    logic signed [EXPN_W-1:0]  r_expn;
    logic                      r_tsat;
    logic                      r_vneg;
    svmc_pkg::t_freq           r_cutoff;
    logic                      r_sync;

    // output register
    logic            r_out_valid;
    svmc_pkg::t_freq r_out_cutoff, r_out_osc;
    logic            r_out_sync;

    // multiplier interface
    logic                     w_mul_en;
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    logic w_in_acc, w_out_load;

    // views of the last product
    logic [16:0]              w_k2;
    logic [18:0]              w_k4;
    logic signed [ACC_W-1:0]  w_sh6, w_sh15;
    logic signed [MUL_W-1:0]  w_kt;
    logic [15:0]              w_poly;
    logic [16:0]              w_m;
    svmc_pkg::t_freq          w_sq;
    logic [svmc_pkg::QUOT_W-1:0] w_q;
    logic [31:0]              w_vabs, w_acc_abs;
    logic signed [24:0]       w_pitch_d;

    // exponent split and scaler
    logic signed [ACC_W-1:0]  w_exp_arg, w_e14, w_expn_raw;
    logic signed [EXPN_W-1:0] w_expn;
    logic [15:0]              w_frac;
    logic [39:0]              w_t;
    logic                     w_t_big;
    svmc_pkg::t_freq          w_cut, w_osc;

    svmc_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_load  = (r_state == ST_DONE) && (!r_out_valid || o_rsp.ready);

    // product slices; bounds follow from operand ranges of each step
    assign w_k2   = w_prod[31:15];
    assign w_k4   = w_prod[33:15];
    assign w_sh6  = ACC_W'(w_prod >>> 6);
    assign w_sh15 = ACC_W'(w_prod >>> 15);
    assign w_kt   = MUL_W'(w_prod >>> 16);
    assign w_poly = w_prod[31:16];
    assign w_m    = 17'h10000 + {1'b0, w_poly};
    assign w_sq   = w_prod[47:24];
    assign w_q    = w_prod[svmc_pkg::RECIP6_SHIFT+svmc_pkg::QUOT_W-1:svmc_pkg::RECIP6_SHIFT];
    assign w_vabs    = 32'(w_prod[PROD_W-1] ? -w_prod : w_prod);
    assign w_acc_abs = 32'(r_acc[ACC_W-1] ? -r_acc : r_acc);
    assign w_pitch_d = $signed({1'b0, r_key_pitch}) - $signed({1'b0, svmc_pkg::CPS33});

    // exponent in Q.30 -> Q.16, then integer octave and fraction
    assign w_exp_arg  = (r_state == ST_OEXP) ? r_acc + ACC_W'(w_prod) : ACC_W'(w_prod);
    assign w_e14      = w_exp_arg >>> 14;
    assign w_expn_raw = w_e14 >>> 16;
    assign w_frac     = w_e14[15:0];
    always_comb begin
        if (w_expn_raw > ACC_W'(svmc_pkg::EXPN_MAX)) begin
            w_expn = svmc_pkg::EXPN_MAX;
        end else if (w_expn_raw < ACC_W'(svmc_pkg::EXPN_MIN)) begin
            w_expn = svmc_pkg::EXPN_MIN;
        end else begin
            w_expn = EXPN_W'(w_expn_raw);
        end
    end

    // shared octave shifter, used for cutoff and oscillator
    assign w_t     = f_exp_shift(w_prod[47:0], r_expn);
    assign w_t_big = |w_t[39:24];
    assign w_osc   = w_t_big ? svmc_pkg::FREQ_MAX : w_t[23:0];

    // cutoff clamp to [CPS(20), 0.999]
    always_comb begin
        if (r_tsat || w_sq >= svmc_pkg::CUTOFF_MAX) begin
            w_cut = svmc_pkg::CUTOFF_MAX;
        end else if (w_sq <= svmc_pkg::CPS20) begin
            w_cut = svmc_pkg::CPS20;
        end else begin
            w_cut = w_sq;
        end
    end

    // sequencer: next step and multiplier operands
    always_comb begin
        n_state  = r_state;
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (r_state) inside
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LK2;
                end
            end
            ST_LK2: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(r_lfo_knob));
                w_mul_b  = f_uop(32'(r_lfo_knob));
                n_state  = ST_LK4;
            end
            ST_LK4: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(w_k2));
                w_mul_b  = f_uop(32'(w_k2));
                n_state  = ST_LTERM;
            end
            ST_LTERM: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_lfo);
                w_mul_b  = f_uop(32'(w_k4));
                n_state  = ST_EK2;
            end
            ST_EK2: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(r_env_knob));
                w_mul_b  = f_uop(32'(r_env_knob));
                n_state  = ST_EK4;
            end
            ST_EK4: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(w_k2));
                w_mul_b  = f_uop(32'(w_k2));
                n_state  = ST_ETERM;
            end
            ST_ETERM: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_env);
                w_mul_b  = f_uop(32'(w_k4));
                n_state  = ST_KT;
            end
            ST_KT: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(w_pitch_d);
                w_mul_b  = f_uop(32'(svmc_pkg::TRACK_RECIP));
                n_state  = ST_KTD;
            end
            ST_KTD: begin
                w_mul_en = 1'b1;
                w_mul_a  = w_kt;
                w_mul_b  = f_uop(32'(r_key_track));
                n_state  = ST_FBEND;
            end
            ST_FBEND: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_bend);
                w_mul_b  = f_uop(32'(r_bend_fdepth));
                n_state  = ST_FEXP;
            end
            ST_FEXP, ST_OEXP: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(svmc_pkg::EXP_C3));
                w_mul_b  = f_uop(32'(w_frac));
                n_state  = (r_state == ST_FEXP) ? ST_FP2 : ST_OP2;
            end
            ST_FP2, ST_OP2: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(svmc_pkg::EXP_C2) + 32'(w_poly));
                w_mul_b  = f_uop(32'(r_frac));
                n_state  = (r_state == ST_FP2) ? ST_FP1 : ST_OP1;
            end
            ST_FP1, ST_OP1: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(svmc_pkg::EXP_C1) + 32'(w_poly));
                w_mul_b  = f_uop(32'(r_frac));
                n_state  = (r_state == ST_FP1) ? ST_FSCL : ST_OSCL;
            end
            ST_FSCL: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(r_mag);
                w_mul_b  = f_uop(32'(w_m));
                n_state  = ST_FSQ;
            end
            ST_FSQ: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(w_t[23:0]));
                w_mul_b  = f_uop(32'(w_t[23:0]));
                n_state  = ST_FSQ2;
            end
            ST_FSQ2: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(w_sq));
                w_mul_b  = f_uop(32'(w_sq));
                n_state  = ST_VIB;
            end
            ST_VIB: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_lfo);
                w_mul_b  = f_uop(32'(r_vib_depth));
                n_state  = ST_DIV6;
            end
            ST_DIV6: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(w_vabs);
                w_mul_b  = f_uop(svmc_pkg::RECIP6);
                n_state  = ST_OBEND;
            end
            ST_OBEND: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_W'(r_bend);
                w_mul_b  = f_uop(32'(r_bend_odepth));
                n_state  = ST_OEXP;
            end
            ST_OSCL: begin
                w_mul_en = 1'b1;
                w_mul_a  = f_uop(32'(r_key_pitch));
                w_mul_b  = f_uop(32'(w_m));
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and stored sources
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_cutoff_base <= '0;
            r_key_track   <= '0;
            r_lfo_knob    <= '0;
            r_env_knob    <= '0;
            r_env_inv     <= 1'b0;
            r_bend_fdepth <= '0;
            r_bend_odepth <= '0;
            r_vib_depth   <= '0;
            r_key_pitch   <= '0;
            r_lfo         <= '0;
            r_env         <= '0;
            r_bend        <= '0;
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    svmc_pkg::CFG_CUTOFF_BASE:   r_cutoff_base <= i_cfg_data;
                    svmc_pkg::CFG_KEY_TRACK:     r_key_track   <= i_cfg_data;
                    svmc_pkg::CFG_FILT_LFO_KNOB: r_lfo_knob    <= i_cfg_data;
                    svmc_pkg::CFG_FILT_ENV_KNOB: r_env_knob    <= i_cfg_data;
                    svmc_pkg::CFG_ENV_INVERT:    r_env_inv     <= i_cfg_data[0];
                    svmc_pkg::CFG_BEND_FILT:     r_bend_fdepth <= i_cfg_data;
                    svmc_pkg::CFG_BEND_OSC:      r_bend_odepth <= i_cfg_data;
                    svmc_pkg::CFG_VIB_DEPTH:     r_vib_depth   <= i_cfg_data;
                endcase
            end

            // saturate the new value into its source
            if (w_in_acc) begin
                unique case (i_req.req_type)
                    svmc_pkg::REQ_KEY: begin
                        r_key_pitch <= i_req.source_value[24] ? '0
                                                              : i_req.source_value[23:0];
                    end
                    svmc_pkg::REQ_LFO: begin
                        if (i_req.source_value > 25'sd32767) begin
                            r_lfo <= 16'sh7FFF;
                        end else if (i_req.source_value < -25'sd32768) begin
                            r_lfo <= 16'sh8000;
                        end else begin
                            r_lfo <= i_req.source_value[15:0];
                        end
                    end
                    svmc_pkg::REQ_ENV: begin
                        if (i_req.source_value > 25'sd65535) begin
                            r_env <= 17'sh0FFFF;
                        end else if (i_req.source_value < -25'sd65536) begin
                            r_env <= 17'sh10000;
                        end else begin
                            r_env <= i_req.source_value[16:0];
                        end
                    end
                    svmc_pkg::REQ_BEND: begin
                        if (i_req.source_value > 25'sd32767) begin
                            r_bend <= 16'sh7FFF;
                        end else if (i_req.source_value < -25'sd32768) begin
                            r_bend <= 16'sh8000;
                        end else begin
                            r_bend <= i_req.source_value[15:0];
                        end
                    end
                endcase
            end
        end
    end

    // datapath registers, updated per step
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_acc  <= $signed({9'b0, r_cutoff_base, 9'b0});
                    r_sync <= (i_req.req_type == svmc_pkg::REQ_KEY);
                end
            end
            ST_EK2: begin
                r_acc <= r_acc + w_sh6;                 // lfo term
            end
            ST_KT: begin
                r_acc <= r_env_inv ? r_acc - w_sh6 : r_acc + w_sh6;  // envelope term
            end
            ST_FBEND: begin
                r_acc <= r_acc + w_sh15;                // key tracking term
            end
            ST_FEXP: begin
                r_expn <= w_expn;
                r_frac <= w_frac;
                r_mag  <= w_acc_abs;
            end
            ST_FSQ: begin
                r_tsat <= w_t_big;
            end
            ST_VIB: begin
                r_cutoff <= w_cut;
            end
            ST_DIV6: begin
                r_vneg <= w_prod[PROD_W-1];
            end
            ST_OBEND: begin
                // vibrato exponent, quotient truncated toward zero
                r_acc <= r_vneg ? -$signed({5'b0, w_q}) : $signed({5'b0, w_q});
            end
            ST_OEXP: begin
                r_expn <= w_expn;
                r_frac <= w_frac;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    r_out_cutoff <= r_cutoff;
                    r_out_osc    <= w_osc;
                    r_out_sync   <= r_sync;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.filter_cutoff = r_out_cutoff;
    assign o_rsp.osc_freq      = r_out_osc;
    assign o_rsp.sub_osc_freq  = {1'b0, r_out_osc[23:1]};
    assign o_rsp.osc_sync      = r_out_sync;

    // checks
    `SVMC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc,
        !i_req.ready && r_state == ST_LK2, "sequencer did not start on accepted transaction")
    `SVMC_ASSERT_IMP(a_cutoff_range, i_clk, i_rst_n, r_out_valid,
        r_out_cutoff >= svmc_pkg::CPS20 && r_out_cutoff <= svmc_pkg::CUTOFF_MAX,
        "filter cutoff outside clamp range")
    `SVMC_ASSERT_IMP(a_expn_range, i_clk, i_rst_n, r_state == ST_FSQ || r_state == ST_DONE,
        r_expn >= svmc_pkg::EXPN_MIN && r_expn <= svmc_pkg::EXPN_MAX,
        "octave shift outside scaler range")
    `SVMC_ASSERT_NXT(a_done_holds, i_clk, i_rst_n,
        r_state == ST_DONE && r_out_valid && !o_rsp.ready,
        r_state == ST_DONE && r_out_valid, "finished result lost while output stalled")

endmodule
